// File: rtl/owbm_pkg.sv
// Package for the one-wire bus master: payload structs, command codes,
// phase encoding and register indexes. No dependencies.
package owbm_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 10;

   // command selector codes
   localparam logic [1:0] FUNC_NONE  = 2'd0;
   localparam logic [1:0] FUNC_RESET = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;
   localparam logic [1:0] FUNC_READ  = 2'd3;

   // reset status codes
   localparam logic [1:0] STAT_PRESENT = 2'd0;
   localparam logic [1:0] STAT_ABSENT  = 2'd1;
   localparam logic [1:0] STAT_STUCK   = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESET_TAIL    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_ONE_LOW = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WRITE_ZERO_LOW = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOT          = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_LOW      = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_READ_SAMPLE   = 3'd7;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] write_data;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] reset_status;
      logic [7:0] read_data;
   } rsp_type;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_RLOW  = 6'b000010,
      PH_RWAIT = 6'b000100,
      PH_RTAIL = 6'b001000,
      PH_WBIT  = 6'b010000,
      PH_RDBIT = 6'b100000
   } phase_type;

endpackage

// File: rtl/owbm_front.sv
// Front end of the one-wire bus master: takes tick transactions into a
// two-entry queue that decouples input stalls from the bus engine. Uses owbm_pkg.
module owbm_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  owbm_pkg::req_type req_payload,
   output logic             item_valid,
   output owbm_pkg::req_type item,
   input  logic             item_pop
);
   import owbm_pkg::*;

   req_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall  = (count_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_payload;
      end
   end

endmodule

// File: rtl/owbm_back.sv
// Back end of the one-wire bus master: timing registers, bus phase state
// machine and the result register. Uses owbm_pkg.
module owbm_back #(
   parameter int COUNT_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [owbm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [owbm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  logic                                  item_valid,
   input  owbm_pkg::req_type                     item,
   output logic                                  item_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output owbm_pkg::rsp_type                     rsp_payload
);
   import owbm_pkg::*;

   localparam int CW = (COUNT_BITS > 11) ? COUNT_BITS : 11;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // timing registers
   logic [9:0] reset_low_ff;
   logic [7:0] presence_wait_ff;
   logic [9:0] reset_tail_ff;
   logic [6:0] write_one_low_ff;
   logic [6:0] write_zero_low_ff;
   logic [7:0] slot_ff;
   logic [5:0] read_low_ff;
   logic [5:0] read_sample_ff;

   phase_type             phase_ff, phase_in;
   logic [COUNT_BITS-1:0] tc_ff, tc_in;
   logic [2:0]            bi_ff, bi_in;
   logic [7:0]            sb_ff, sb_in;
   logic [1:0]            status_ff, status_in;
   logic [7:0]            rdres_ff, rdres_in;
   logic                  drive, done;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   function automatic logic reached(input logic [COUNT_BITS-1:0] t, input logic [CW-1:0] len);
      return (CW'(t) >= len) || (t == CNT_MAX);
   endfunction

   assign item_pop    = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff      <= 10'd480;
         presence_wait_ff  <= 8'd70;
         reset_tail_ff     <= 10'd410;
         write_one_low_ff  <= 7'd6;
         write_zero_low_ff <= 7'd60;
         slot_ff           <= 8'd70;
         read_low_ff       <= 6'd6;
         read_sample_ff    <= 6'd9;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RESET_LOW:      reset_low_ff      <= csr_wdata;
            CSR_PRESENCE_WAIT:  presence_wait_ff  <= csr_wdata[7:0];
            CSR_RESET_TAIL:     reset_tail_ff     <= csr_wdata;
            CSR_WRITE_ONE_LOW:  write_one_low_ff  <= csr_wdata[6:0];
            CSR_WRITE_ZERO_LOW: write_zero_low_ff <= csr_wdata[6:0];
            CSR_SLOT:           slot_ff           <= csr_wdata[7:0];
            CSR_READ_LOW:       read_low_ff       <= csr_wdata[5:0];
            CSR_READ_SAMPLE:    read_sample_ff    <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      phase_type             ph;
      logic [COUNT_BITS-1:0] tc;
      logic [COUNT_BITS-1:0] tc_up;
      logic [2:0]            bi;
      logic [7:0]            sb;
      logic [6:0]            low;
      logic [6:0]            at;
      logic [7:0]            len;
      logic [9:0]            rlow;

      ph   = phase_ff;
      tc   = tc_ff;
      bi   = bi_ff;
      sb   = sb_ff;
      drive = 1'b0;
      done  = 1'b0;
      status_in = status_ff;
      rdres_in  = rdres_ff;

      // a command starts only from idle and that tick is its first
      if (phase_ff == PH_IDLE && item.func != FUNC_NONE) begin
         tc = '0;
         bi = '0;
         unique case (item.func)
            FUNC_RESET: ph = PH_RLOW;
            FUNC_WRITE: begin
               ph = PH_WBIT;
               sb = item.write_data;
            end
            default: begin
               ph = PH_RDBIT;
               sb = 8'd0;
            end
         endcase
      end

      tc_up = (tc == CNT_MAX) ? tc : tc + 1'b1;
      low   = sb[bi] ? write_one_low_ff : write_zero_low_ff;
      at    = 7'(read_low_ff) + 7'(read_sample_ff);
      rlow  = (reset_low_ff == 10'd0) ? 10'd1 : reset_low_ff;
      len   = 8'd0;

      phase_in = ph;
      tc_in    = tc;
      bi_in    = bi;
      sb_in    = sb;

      unique case (ph)
         PH_RLOW: begin
            drive = 1'b1;
            tc_in = tc_up;
            if (reached(tc_up, CW'(rlow))) begin
               phase_in = PH_RWAIT;
               tc_in    = '0;
            end
         end
         PH_RWAIT: begin
            if (reached(tc, CW'(presence_wait_ff))) begin
               status_in = item.line_level ? STAT_ABSENT : STAT_PRESENT;
               phase_in  = PH_RTAIL;
               tc_in     = '0;
            end else begin
               tc_in = tc_up;
            end
         end
         PH_RTAIL: begin
            tc_in = tc_up;
            if (reached(tc_up, CW'(reset_tail_ff))) begin
               if (!item.line_level) begin
                  status_in = STAT_STUCK;
               end
               phase_in = PH_IDLE;
               tc_in    = '0;
               done     = 1'b1;
            end
         end
         PH_WBIT: begin
            len   = (slot_ff > 8'(low)) ? slot_ff : 8'(low) + 8'd1;
            drive = (CW'(tc) < CW'(low));
            tc_in = tc_up;
            if (reached(tc_up, CW'(len))) begin
               tc_in = '0;
               if (bi == 3'd7) begin
                  phase_in = PH_IDLE;
                  bi_in    = '0;
                  done     = 1'b1;
               end else begin
                  bi_in = bi + 3'd1;
               end
            end
         end
         PH_RDBIT: begin
            len   = (slot_ff > 8'(at)) ? slot_ff : 8'(at) + 8'd1;
            drive = (CW'(tc) < CW'(read_low_ff));
            if (CW'(tc) == CW'(at)) begin
               sb_in = {item.line_level, sb[7:1]};
            end
            tc_in = tc_up;
            if (reached(tc_up, CW'(len))) begin
               tc_in = '0;
               if (bi == 3'd7) begin
                  rdres_in = sb_in;
                  phase_in = PH_IDLE;
                  bi_in    = '0;
                  done     = 1'b1;
               end else begin
                  bi_in = bi + 3'd1;
               end
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tc_ff        <= '0;
         bi_ff        <= '0;
         sb_ff        <= '0;
         status_ff    <= STAT_PRESENT;
         rdres_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            phase_ff  <= phase_in;
            tc_ff     <= tc_in;
            bi_ff     <= bi_in;
            sb_ff     <= sb_in;
            status_ff <= status_in;
            rdres_ff  <= rdres_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         rsp_ff.drive_low    <= drive;
         rsp_ff.busy_res     <= (phase_in != PH_IDLE);
         rsp_ff.done_res     <= done;
         rsp_ff.reset_status <= status_in;
         rsp_ff.read_data    <= rdres_in;
      end
   end

endmodule

// File: rtl/onewire_bus_master.sv
// Top level of the one-wire bus master: front queue plus bus engine.
// Depends on owbm_pkg, owbm_front and owbm_back.
//
//   channel | direction | payload     | handshake
//   req     | in        | req_type    | req_valid / req_stall
//   rsp     | out       | rsp_type    | rsp_valid / rsp_stall
//   csr     | in        | 10-bit data | csr_we, csr_index (write only)
//
// One tick transaction in, one result out; a new tick is taken every cycle while the front queue is not full.
// Each tick passes through the front queue and then the engine's result register.
// The tick counter in the engine advances at most once per transaction, never per clock.
// Synchronous active-high reset restores default timing and the idle phase.
// A stalled result holds; the two-entry queue absorbs input while the output waits.
module onewire_bus_master #(
   parameter int COUNT_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  owbm_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output owbm_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_we,
   input  logic [owbm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [owbm_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import owbm_pkg::*;

   logic    item_valid;
   logic    item_pop;
   req_type item;

   owbm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop)
   );

   owbm_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_valid  (item_valid),
      .item        (item),
      .item_pop    (item_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: test/onewire_bus_master_checker.sv
// Result checker for the one-wire bus master: keeps its own model of the bus timing,
// predicts one result per accepted tick transaction and compares it with the block.
// Depends on owbm_pkg.
module onewire_bus_master_checker #(
   parameter int COUNT_BITS = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  owbm_pkg::req_type                   req_payload,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  owbm_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_we,
   input  logic [owbm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [owbm_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output int                                  mismatches,
   output int                                  pending,
   output logic                                engine_idle
);
   timeunit 1ns;
   timeprecision 1ps;

   import owbm_pkg::*;

   localparam logic [COUNT_BITS-1:0] TICK_MAX = '1;

   // timing registers
   logic [9:0] lim_reset_low, lim_reset_tail;
   logic [7:0] lim_presence, lim_slot;
   logic [6:0] lim_one_low, lim_zero_low;
   logic [5:0] lim_read_low, lim_read_sample;

   // bus engine state
   phase_type             bus_phase;
   logic [COUNT_BITS-1:0] tick_cnt;
   logic [2:0]            bit_pos;
   logic [7:0]            shift_reg;
   logic [7:0]            rd_byte;
   logic [1:0]            status;

   rsp_type bus_outputs_due[$];
   int      err_cnt = 0;

   function automatic void tick_up();
      if (tick_cnt != TICK_MAX)
         tick_cnt = tick_cnt + 1'b1;
   endfunction

   // a phase also ends when the counter pins at its maximum
   function automatic bit tick_hit(int len);
      return int'(tick_cnt) >= len || tick_cnt == TICK_MAX;
   endfunction

   function automatic rsp_type advance_bus(req_type t);
      rsp_type r;
      int      pulse;
      int      span;
      int      sample_at;
      logic    wbit;
      r = '0;
      if (bus_phase == PH_IDLE && t.func != FUNC_NONE) begin
         tick_cnt = '0;
         bit_pos = '0;
         case (t.func)
            FUNC_RESET: bus_phase = PH_RLOW;
            FUNC_WRITE: begin
               bus_phase = PH_WBIT;
               shift_reg = t.write_data;
            end
            default: begin
               bus_phase = PH_RDBIT;
               shift_reg = '0;
            end
         endcase
      end
      case (bus_phase)
         PH_RLOW: begin
            r.drive_low = 1'b1;
            tick_up();
            if (tick_hit(lim_reset_low == 0 ? 1 : int'(lim_reset_low))) begin
               bus_phase = PH_RWAIT;
               tick_cnt = '0;
            end
         end
         PH_RWAIT: begin
            if (tick_hit(int'(lim_presence))) begin
               status = t.line_level ? STAT_ABSENT : STAT_PRESENT;
               bus_phase = PH_RTAIL;
               tick_cnt = '0;
            end else begin
               tick_up();
            end
         end
         PH_RTAIL: begin
            tick_up();
            if (tick_hit(int'(lim_reset_tail))) begin
               if (!t.line_level)
                  status = STAT_STUCK;
               bus_phase = PH_IDLE;
               tick_cnt = '0;
               r.done_res = 1'b1;
            end
         end
         PH_WBIT: begin
            wbit = shift_reg[bit_pos];
            pulse = wbit ? int'(lim_one_low) : int'(lim_zero_low);
            // a slot no longer than its pulse is stretched to leave one released tick
            span = int'(lim_slot) > pulse ? int'(lim_slot) : pulse + 1;
            r.drive_low = int'(tick_cnt) < pulse;
            tick_up();
            if (tick_hit(span)) begin
               tick_cnt = '0;
               if (bit_pos == 3'd7) begin
                  bus_phase = PH_IDLE;
                  r.done_res = 1'b1;
               end
               bit_pos = bit_pos + 3'd1;
            end
         end
         PH_RDBIT: begin
            sample_at = int'(lim_read_low) + int'(lim_read_sample);
            span = int'(lim_slot) > sample_at ? int'(lim_slot) : sample_at + 1;
            r.drive_low = int'(tick_cnt) < int'(lim_read_low);
            if (int'(tick_cnt) == sample_at)
               shift_reg = {t.line_level, shift_reg[7:1]};
            tick_up();
            if (tick_hit(span)) begin
               tick_cnt = '0;
               if (bit_pos == 3'd7) begin
                  rd_byte = shift_reg;
                  bus_phase = PH_IDLE;
                  r.done_res = 1'b1;
               end
               bit_pos = bit_pos + 3'd1;
            end
         end
         default: bus_phase = PH_IDLE;
      endcase
      r.busy_res = bus_phase != PH_IDLE;
      r.reset_status = status;
      r.read_data = rd_byte;
      return r;
   endfunction

   function automatic void write_timing(logic [CSR_INDEX_BITS-1:0] idx,
                                        logic [CSR_DATA_BITS-1:0] val);
      case (idx)
         CSR_RESET_LOW:      lim_reset_low = val;
         CSR_PRESENCE_WAIT:  lim_presence = val[7:0];
         CSR_RESET_TAIL:     lim_reset_tail = val;
         CSR_WRITE_ONE_LOW:  lim_one_low = val[6:0];
         CSR_WRITE_ZERO_LOW: lim_zero_low = val[6:0];
         CSR_SLOT:           lim_slot = val[7:0];
         CSR_READ_LOW:       lim_read_low = val[5:0];
         CSR_READ_SAMPLE:    lim_read_sample = val[5:0];
         default: ;
      endcase
   endfunction

   function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         err_cnt++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         lim_reset_low = 10'd480;
         lim_presence = 8'd70;
         lim_reset_tail = 10'd410;
         lim_one_low = 7'd6;
         lim_zero_low = 7'd60;
         lim_slot = 8'd70;
         lim_read_low = 6'd6;
         lim_read_sample = 6'd9;
         bus_phase = PH_IDLE;
         tick_cnt = '0;
         bit_pos = '0;
         shift_reg = '0;
         rd_byte = '0;
         status = STAT_PRESENT;
         bus_outputs_due.delete();
      end else begin
         if (csr_we)
            write_timing(csr_index, csr_wdata);
         if (req_valid && !req_stall)
            bus_outputs_due.push_back(advance_bus(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (bus_outputs_due.size() == 0) begin
               err_cnt++;
               $display("%0t: result with no transaction waiting, expected none, got %h",
                        $time, rsp_payload);
            end else begin
               want = bus_outputs_due.pop_front();
               compare_field("drive_low", 8'(want.drive_low), 8'(rsp_payload.drive_low));
               compare_field("busy_res", 8'(want.busy_res), 8'(rsp_payload.busy_res));
               compare_field("done_res", 8'(want.done_res), 8'(rsp_payload.done_res));
               compare_field("reset_status", 8'(want.reset_status),
                             8'(rsp_payload.reset_status));
               compare_field("read_data", want.read_data, rsp_payload.read_data);
            end
         end
      end
      mismatches <= err_cnt;
      pending <= bus_outputs_due.size();
      engine_idle <= (bus_phase == PH_IDLE);
   end

endmodule

// File: test/onewire_bus_master_tb.sv
// Testbench top for the one-wire bus master: clock, reset, tick and register stimulus,
// watchdog and verdict. Depends on owbm_pkg, onewire_bus_master and its checker.
module onewire_bus_master_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import owbm_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 5;
   localparam int PHASE_TICKS    = 80;

   localparam logic [CSR_INDEX_BITS-1:0] TIMING_REGS [8] = '{
      CSR_RESET_LOW, CSR_PRESENCE_WAIT, CSR_RESET_TAIL, CSR_WRITE_ONE_LOW,
      CSR_WRITE_ZERO_LOW, CSR_SLOT, CSR_READ_LOW, CSR_READ_SAMPLE};
   localparam int REG_BITS  [8] = '{10, 8, 10, 7, 7, 8, 6, 6};
   localparam int SHORT_MAX [8] = '{12, 10, 12, 8, 16, 20, 6, 8};
   localparam int PACE_PCT  [4] = '{0, 5, 15, 40};

   typedef enum logic [1:0] {LINE_RANDOM, LINE_HIGH, LINE_LOW, LINE_RELEASE} line_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_payload;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_payload;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   int   mismatches;
   int   pending;
   logic engine_idle;

   int            gap_pct;
   int            stall_pct;
   bit            quiet;
   line_mode_type line_mode;
   int            release_at;
   int            cmd_age;
   int            idle_cycles;
   logic [9:0]    timing_set [8];

   onewire_bus_master #(.COUNT_BITS(10)) DUT (
      .clock, .reset,
      .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_we, .csr_index, .csr_wdata
   );

   onewire_bus_master_checker #(.COUNT_BITS(10)) bus_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_payload,
      .rsp_valid, .rsp_stall, .rsp_payload,
      .csr_we, .csr_index, .csr_wdata,
      .mismatches, .pending, .engine_idle
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver back-pressure in random bursts
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("onewire_bus_master test failed");
            $finish;
         end
      end
   end

   function automatic logic pick_line();
      case (line_mode)
         LINE_HIGH:    return 1'b1;
         LINE_LOW:     return 1'b0;
         LINE_RELEASE: return cmd_age >= release_at;
         default:      return 1'($urandom_range(1));
      endcase
   endfunction

   task automatic send_tick(input logic [1:0] fn, input logic [7:0] data, input logic line);
      req_payload <= '{func: fn, write_data: data, line_level: line};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic paced_tick(input logic [1:0] fn, input logic [7:0] data, input logic line);
      if (!quiet && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      send_tick(fn, data, line);
   endtask

   // engine_idle is registered and trails the last accepted transaction, hence the do-while
   task automatic run_cmd(input logic [1:0] fn, input logic [7:0] data,
                          input line_mode_type mode, input int cut, input bit noisy);
      line_mode = mode;
      release_at = cut;
      cmd_age = 0;
      paced_tick(fn, data, pick_line());
      do begin
         cmd_age++;
         paced_tick(noisy ? 2'($urandom_range(3)) : FUNC_NONE, 8'($urandom), pick_line());
      end while (!engine_idle);
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic load_timing();
      do paced_tick(FUNC_NONE, 8'($urandom), 1'($urandom)); while (!engine_idle);
      wait_results();
      for (int k = 0; k < 8; k++) begin
         csr_we <= 1'b1;
         csr_index <= TIMING_REGS[k];
         csr_wdata <= timing_set[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // short timings, with junk above each register's width now and then
   task automatic pick_short_timing();
      int v;
      for (int k = 0; k < 8; k++) begin
         v = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, SHORT_MAX[k]);
         if ($urandom_range(3) == 0)
            v = v | (($urandom_range(1023) >> REG_BITS[k]) << REG_BITS[k]);
         timing_set[k] = 10'(v);
      end
   endtask

   task automatic random_ticks(input int n);
      logic [1:0] fn;
      for (int i = 0; i < n; i++) begin
         cmd_age++;
         if (engine_idle && $urandom_range(99) < 50) begin
            fn = 2'($urandom_range(1, 3));
            line_mode = line_mode_type'($urandom_range(3));
            release_at = $urandom_range(1, 30);
            cmd_age = 0;
         end else if ($urandom_range(99) < 15) begin
            fn = 2'($urandom_range(3));
         end else begin
            fn = FUNC_NONE;
         end
         paced_tick(fn, 8'($urandom), pick_line());
         if (!quiet && $urandom_range(199) == 0)
            wait_results();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_index = CSR_RESET_LOW;
      csr_wdata = '0;
      quiet = 1'b0;
      gap_pct = 10;
      stall_pct = 10;
      line_mode = LINE_RANDOM;
      release_at = 0;
      cmd_age = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // timing straight out of reset
      run_cmd(FUNC_WRITE, 8'h96, LINE_HIGH, 0, 1'b0);

      timing_set = '{10'd2, 10'd3, 10'd2, 10'd1, 10'd4, 10'd6, 10'd1, 10'd2};
      load_timing();
      run_cmd(FUNC_RESET, 8'h00, LINE_HIGH, 0, 1'b0);
      run_cmd(FUNC_RESET, 8'hFF, LINE_LOW, 0, 1'b0);
      // device answers during the presence window and lets go before the stuck check
      run_cmd(FUNC_RESET, 8'h00, LINE_RELEASE, 6, 1'b0);
      run_cmd(FUNC_WRITE, 8'h00, LINE_HIGH, 0, 1'b0);
      run_cmd(FUNC_WRITE, 8'hFF, LINE_HIGH, 0, 1'b0);
      run_cmd(FUNC_WRITE, 8'hA5, LINE_RANDOM, 0, 1'b1);
      run_cmd(FUNC_READ, 8'h00, LINE_HIGH, 0, 1'b0);
      run_cmd(FUNC_READ, 8'h00, LINE_LOW, 0, 1'b0);
      run_cmd(FUNC_READ, 8'h5A, LINE_RANDOM, 0, 1'b1);

      // zero lengths everywhere
      timing_set = '{10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0};
      load_timing();
      run_cmd(FUNC_RESET, 8'h00, LINE_RANDOM, 0, 1'b0);
      run_cmd(FUNC_WRITE, 8'h5A, LINE_RANDOM, 0, 1'b0);
      run_cmd(FUNC_READ, 8'h00, LINE_RANDOM, 0, 1'b0);

      // slots shorter than their pulses
      timing_set = '{10'd5, 10'd5, 10'd5, 10'd8, 10'd12, 10'd4, 10'd5, 10'd6};
      load_timing();
      run_cmd(FUNC_WRITE, 8'h0F, LINE_RANDOM, 0, 1'b0);
      run_cmd(FUNC_READ, 8'h00, LINE_RANDOM, 0, 1'b0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         gap_pct = PACE_PCT[$urandom_range(3)];
         stall_pct = PACE_PCT[$urandom_range(3)];
         pick_short_timing();
         load_timing();
         random_ticks(PHASE_TICKS);
      end

      pick_short_timing();
      load_timing();
      quiet = 1'b1;
      random_ticks(PHASE_TICKS);

      wait_results();
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending == 0)
         $display("onewire_bus_master test passed");
      else
         $display("onewire_bus_master test failed");
      $finish;
   end

endmodule
